### rtl/core/fbpa_pkg.sv
package fbpa_pkg;

    // request codes
    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    // controller states
    typedef enum logic [1:0] {
        FSM_INIT,
        FSM_IDLE,
        FSM_EXEC
    } fsm_t;

    localparam int OPCODE_W = 1;
    localparam int MARGIN_W = 7;
    localparam int BLKIDX_W = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int IDX_SPAN = 64;

endpackage

### rtl/core/fixed_block_pool_allocator.sv
// A word accepted with start high and busy low moves the controller to its execute state;
// the result words and done are registered as it leaves that state. No new word is taken
// while busy is high; the registered read of the link memory precedes each update. The
// receiver cannot stall: done lasts one cycle. Reset: the head, count and low-watermark
// reset at once; the link memory is then chained by a clearing pass, while busy stays high.
module fixed_block_pool_allocator #(
    parameter int BLOCKS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [fbpa_pkg::OPCODE_W-1:0]    opcode,
    input  logic [fbpa_pkg::MARGIN_W-1:0]    margin,
    input  logic [fbpa_pkg::BLKIDX_W-1:0]    block_index,
    output logic                             done,
    output logic [fbpa_pkg::STATUS_W-1:0]    status,
    output logic [fbpa_pkg::BLKIDX_W-1:0]    granted_block,
    output logic [fbpa_pkg::COUNT_W-1:0]     free_count,
    output logic [fbpa_pkg::COUNT_W-1:0]     min_free
);

    // index width and count width (count also holds BLOCKS as end of chain)
    localparam int IW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int CW = $clog2(BLOCKS + 1);
    localparam int MW = (CW > fbpa_pkg::MARGIN_W) ? CW : fbpa_pkg::MARGIN_W;

    // block index reduced modulo BLOCKS: constant table
    logic [IW-1:0] blk_tab [fbpa_pkg::IDX_SPAN];
    for (genvar g = 0; g < fbpa_pkg::IDX_SPAN; g++)
    begin : g_tab
        assign blk_tab[g] = IW'(g % BLOCKS);
    end

    fbpa_pkg::fsm_t state_reg, state_next;

    logic [CW-1:0] clr_reg, clr_next;
    logic [CW-1:0] head_reg, head_next;
    logic [CW-1:0] free_reg, free_next;
    logic [CW-1:0] low_reg, low_next;

    logic                          op_reg;
    logic [fbpa_pkg::MARGIN_W-1:0] margin_reg;
    logic [IW-1:0]                 blk_reg;

    logic                          done_reg;
    logic [fbpa_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [fbpa_pkg::BLKIDX_W-1:0] granted_reg, granted_next;
    logic [fbpa_pkg::COUNT_W-1:0]  fcount_reg;
    logic [fbpa_pkg::COUNT_W-1:0]  minf_reg;

    // link memory, one write and one registered read port
    logic [CW-1:0] link_mem [BLOCKS];
    logic [CW-1:0] rd_data_reg;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [CW-1:0] mem_wdata;
    logic [IW-1:0] hd_eff;
    logic          accept;

    // broken chain falls back to block 0
    assign hd_eff = (head_reg >= CW'(BLOCKS)) ? '0 : head_reg[IW-1:0];
    assign busy   = (state_reg != fbpa_pkg::FSM_IDLE);
    assign accept = start && !busy;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= link_mem[hd_eff];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fbpa_pkg::FSM_INIT;
            clr_reg   <= '0;
            head_reg  <= '0;
            free_reg  <= CW'(BLOCKS);
            low_reg   <= CW'(BLOCKS);
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            head_reg  <= head_next;
            free_reg  <= free_next;
            low_reg   <= low_next;
            done_reg  <= (state_reg == fbpa_pkg::FSM_EXEC);
        end
    end

    // request capture and result words
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= opcode;
            margin_reg <= margin;
            blk_reg    <= blk_tab[block_index];
        end
        if (state_reg == fbpa_pkg::FSM_EXEC)
        begin
            status_reg  <= status_next;
            granted_reg <= granted_next;
            fcount_reg  <= fbpa_pkg::COUNT_W'(free_next);
            minf_reg    <= fbpa_pkg::COUNT_W'(low_next);
        end
    end

    // next state, list update and memory write
    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        head_next    = head_reg;
        free_next    = free_reg;
        low_next     = low_reg;
        mem_we       = 1'b0;
        mem_waddr    = blk_reg;
        mem_wdata    = head_reg;
        status_next  = fbpa_pkg::ST_OK;
        granted_next = '0;
        unique case (state_reg)
            fbpa_pkg::FSM_INIT:
            begin
                // chain entry i to i+1
                mem_we    = 1'b1;
                mem_waddr = clr_reg[IW-1:0];
                mem_wdata = clr_reg + CW'(1);
                clr_next  = clr_reg + CW'(1);
                if (clr_reg == CW'(BLOCKS - 1))
                begin
                    state_next = fbpa_pkg::FSM_IDLE;
                end
            end
            fbpa_pkg::FSM_IDLE:
            begin
                if (start)
                begin
                    state_next = fbpa_pkg::FSM_EXEC;
                end
            end
            fbpa_pkg::FSM_EXEC:
            begin
                state_next = fbpa_pkg::FSM_IDLE;
                if (op_reg == fbpa_pkg::OP_ALLOC)
                begin
                    if (MW'(free_reg) > MW'(margin_reg))
                    begin
                        // pop head; link of head was read on accept
                        granted_next = fbpa_pkg::BLKIDX_W'(hd_eff);
                        head_next    = rd_data_reg;
                        free_next    = free_reg - CW'(1);
                        if (low_reg > free_next)
                        begin
                            low_next = free_next;
                        end
                    end
                    else
                    begin
                        status_next = fbpa_pkg::ST_REFUSED;
                    end
                end
                else
                begin
                    if (free_reg < CW'(BLOCKS))
                    begin
                        // push returned block onto head
                        mem_we    = 1'b1;
                        head_next = CW'(blk_reg);
                        free_next = free_reg + CW'(1);
                    end
                    else
                    begin
                        status_next = fbpa_pkg::ST_FULL;
                    end
                end
            end
            default:
            begin
                state_next = fbpa_pkg::FSM_IDLE;
            end
        endcase
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign granted_block = granted_reg;
    assign free_count    = fcount_reg;
    assign min_free      = minf_reg;

endmodule

### rtl/core/fbpa_checker.sv
module fbpa_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  logic                             done,
    input  logic [fbpa_pkg::STATUS_W-1:0]    status,
    input  logic [fbpa_pkg::BLKIDX_W-1:0]    granted_block
);

    // an accepted word raises busy through the registered state
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // every accepted word is followed by its result, marked by done
    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("result missing two cycles after accept");

    // refused and full results never report a granted block
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != fbpa_pkg::ST_OK) |-> (granted_block == '0))
        else $error("granted block set on refused request");

    // status carries only defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == fbpa_pkg::ST_OK || status == fbpa_pkg::ST_REFUSED
                  || status == fbpa_pkg::ST_FULL))
        else $error("undefined status code");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .granted_block (granted_block)
);
